### hw/rtl/spc_pkg.sv
// ============================================================================
// spc_pkg
// Shared types, codes and constants of the servo position controller.
// ============================================================================
package spc_pkg;

  // Default configuration
  localparam int unsigned PresetSlotsDef = 4;
  localparam int unsigned MsgCharsDef    = 4;

  // Field widths
  localparam int unsigned CmdW    = 3;
  localparam int unsigned DataW   = 8;
  localparam int unsigned ModeW   = 2;
  localparam int unsigned PulseAbW = 13;
  localparam int unsigned PulseCdW = 6;
  localparam int unsigned ChanW   = 3;
  localparam int unsigned SlotW   = 2;
  localparam int unsigned MsgCntW = 3;   // holds 0..4 characters
  localparam int unsigned DigitValW = 10; // up to three decimal digits
  localparam int unsigned OutW    = 48;  // 47 payload bits padded to bytes

  // Operating modes
  typedef enum logic [ModeW-1:0] {
    MODE_MANUAL = 2'd0,
    MODE_PRESET = 2'd1,
    MODE_REMOTE = 2'd2
  } mode_e;

  // Item commands
  typedef enum logic [CmdW-1:0] {
    CMD_MODE = 3'd0,
    CMD_ADC  = 3'd1,
    CMD_SAVE = 3'd2,
    CMD_LOAD = 3'd3,
    CMD_UART = 3'd4
  } cmd_e;

  // Servo indexes
  localparam logic [1:0] SERVO_A = 2'd0;
  localparam logic [1:0] SERVO_B = 2'd1;
  localparam logic [1:0] SERVO_C = 2'd2;
  localparam logic [1:0] SERVO_D = 2'd3;

  // Characters
  localparam logic [7:0] CHAR_A   = 8'h41;
  localparam logic [7:0] CHAR_D   = 8'h44;
  localparam logic [7:0] CHAR_NL  = 8'h0A;
  localparam logic [7:0] CHAR_TAB = 8'h09;
  localparam logic [7:0] CHAR_CR  = 8'h0D;
  localparam logic [7:0] CHAR_SP  = 8'h20;
  localparam logic [7:0] CHAR_0   = 8'h30;
  localparam logic [7:0] CHAR_9   = 8'h39;

  // ADC channel of servo A; later servos count down
  localparam logic [ChanW-1:0] CHAN_FIRST = 3'd6;

  // Scaling constants: A/B = 1200 + 14v + floor(3v/25),
  // C/D = floor((9080 + 106v) / 1000) by reciprocal multiply
  localparam logic [PulseAbW-1:0] AB_BASE   = 13'd1200;
  localparam logic [10:0]         AB_RECIP  = 11'd1311;  // 2^15 / 25, rounded up
  localparam int unsigned         AB_SHIFT  = 15;
  localparam logic [15:0]         CD_BASE   = 16'd9080;
  localparam logic [6:0]          CD_SLOPE  = 7'd106;
  localparam logic [15:0]         CD_RECIP  = 16'd33555; // 2^25 / 1000, rounded up
  localparam int unsigned         CD_SHIFT  = 25;

  // Servo positions
  typedef struct packed {
    logic [PulseAbW-1:0] a;
    logic [PulseAbW-1:0] b;
    logic [PulseCdW-1:0] c;
    logic [PulseCdW-1:0] d;
  } pos_t;

  // Servo update requested by a parsed message
  typedef struct packed {
    logic       valid;
    logic [1:0] idx;
    logic [7:0] value;
  } msg_set_t;

endpackage

### hw/rtl/servo_position_controller.sv
// ============================================================================
// servo_position_controller
// Four-servo controller with manual (ADC), preset and remote (text) modes.
// ============================================================================
// Pipeline: input register, then result register; state is updated as the item
//   enters the result register.
// Throughput: one item per cycle while the sink takes results; the state loop is unpipelined.
// Reset: asynchronous, active low; manual mode, servo A next, positions,
//   presets and slot pointers zero. No clearing pass is needed.
module servo_position_controller import spc_pkg::*; #(
  parameter int unsigned PresetSlots = PresetSlotsDef,
  parameter int unsigned MsgChars    = MsgCharsDef
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            s_axis_tvalid,
  output logic            s_axis_tready,
  input  logic [7:0]      s_axis_tdata,   // data[7:0]
  input  logic [CmdW-1:0] s_axis_tuser,   // cmd[2:0]
  output logic            m_axis_tvalid,
  input  logic            m_axis_tready,
  output logic [OutW-1:0] m_axis_tdata    // mode[1:0], pulse_a[14:2], pulse_b[27:15],
                                          // pulse_c[33:28], pulse_d[39:34],
                                          // next_channel[42:40], save_slot[44:43],
                                          // load_slot[46:45], zero[47]
);

  localparam int unsigned PtrW = (PresetSlots > 1) ? $clog2(PresetSlots) : 1;

  logic              in_valid_q;
  logic [CmdW-1:0]   in_cmd_q;
  logic [7:0]        in_data_q;
  logic              step;
  logic              adv;

  mode_e             mode_q, mode_d;
  logic [1:0]        phase_q, phase_d;
  pos_t              pos_q, pos_d;
  pos_t              preset_q [PresetSlots];
  logic [PtrW-1:0]   save_ptr_q, save_ptr_d;
  logic [PtrW-1:0]   load_ptr_q, load_ptr_d;
  logic              do_save;

  logic              adc_set;
  msg_set_t          msg_set;
  logic              set_en;
  logic [1:0]        set_idx;
  logic [7:0]        set_val;
  logic [PulseAbW-1:0] pulse_ab;
  logic [PulseCdW-1:0] pulse_cd;

  logic [PtrW+1:0]   save_ext;
  logic [PtrW+1:0]   load_ext;
  logic [ChanW-1:0]  next_chan;
  logic              out_valid_q;
  logic [OutW-1:0]   out_data_q;

  // Handshake: result register advances when empty or taken
  assign adv           = !out_valid_q || m_axis_tready;
  assign step          = in_valid_q && adv;
  assign s_axis_tready = !in_valid_q || adv;
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_cmd_q  <= s_axis_tuser;
      in_data_q <= s_axis_tdata;
    end
  end

  // Mode and ADC round-robin
  always_comb begin
    mode_d  = mode_q;
    phase_d = phase_q;
    adc_set = 1'b0;
    if (step) begin
      case (in_cmd_q)
        CMD_MODE: begin
          unique case (mode_q)
            MODE_MANUAL: mode_d = MODE_PRESET;
            MODE_PRESET: mode_d = MODE_REMOTE;
            default: begin
              mode_d  = MODE_MANUAL;
              phase_d = '0;
            end
          endcase
        end
        CMD_ADC: begin
          if (mode_q == MODE_MANUAL) begin
            adc_set = 1'b1;
            phase_d = phase_q + 2'd1;
          end
        end
        default: ;
      endcase
    end
  end

  // Remote message receiver and parser
  spc_msg #(
    .MsgChars (MsgChars)
  ) u_msg (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_i   (step),
    .uart_i   (step && (in_cmd_q == CMD_UART)),
    .data_i   (in_data_q),
    .remote_i (mode_d == MODE_REMOTE),
    .set_o    (msg_set)
  );

  // Shared position scaler; ADC and message updates never coincide
  assign set_en  = adc_set || msg_set.valid;
  assign set_idx = adc_set ? phase_q : msg_set.idx;
  assign set_val = adc_set ? in_data_q : msg_set.value;

  spc_scale u_scale (
    .value_i    (set_val),
    .pulse_ab_o (pulse_ab),
    .pulse_cd_o (pulse_cd)
  );

  // Presets and positions
  always_comb begin
    pos_d      = pos_q;
    save_ptr_d = save_ptr_q;
    load_ptr_d = load_ptr_q;
    do_save    = 1'b0;
    if (step && (mode_q == MODE_PRESET)) begin
      if (in_cmd_q == CMD_SAVE) begin
        do_save    = 1'b1;
        save_ptr_d = (save_ptr_q == PtrW'(PresetSlots - 1)) ? '0 : save_ptr_q + PtrW'(1);
      end
      if (in_cmd_q == CMD_LOAD) begin
        pos_d      = preset_q[load_ptr_q];
        load_ptr_d = (load_ptr_q == PtrW'(PresetSlots - 1)) ? '0 : load_ptr_q + PtrW'(1);
      end
    end
    if (set_en) begin
      unique case (set_idx)
        SERVO_A: pos_d.a = pulse_ab;
        SERVO_B: pos_d.b = pulse_ab;
        SERVO_C: pos_d.c = pulse_cd;
        SERVO_D: pos_d.d = pulse_cd;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q     <= MODE_MANUAL;
      phase_q    <= '0;
      pos_q      <= '0;
      save_ptr_q <= '0;
      load_ptr_q <= '0;
      for (int i = 0; i < PresetSlots; i++) begin
        preset_q[i] <= '0;
      end
    end else begin
      mode_q     <= mode_d;
      phase_q    <= phase_d;
      pos_q      <= pos_d;
      save_ptr_q <= save_ptr_d;
      load_ptr_q <= load_ptr_d;
      if (do_save) begin
        preset_q[save_ptr_q] <= pos_q;
      end
    end
  end

  // Result register
  assign save_ext  = (PtrW + 2)'(save_ptr_d);
  assign load_ext  = (PtrW + 2)'(load_ptr_d);
  assign next_chan = CHAN_FIRST - {1'b0, phase_d};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv) begin
      out_valid_q <= in_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step) begin
      out_data_q <= {1'b0, load_ext[1:0], save_ext[1:0], next_chan,
                     pos_d.d, pos_d.c, pos_d.b, pos_d.a, mode_d};
    end
  end

endmodule

### hw/rtl/spc_scale.sv
// ============================================================================
// spc_scale
// Converts an 8-bit position value into the A/B pulse and C/D compare scales.
// ============================================================================
module spc_scale import spc_pkg::*; (
  input  logic [7:0]          value_i,
  output logic [PulseAbW-1:0] pulse_ab_o,
  output logic [PulseCdW-1:0] pulse_cd_o
);

  logic [9:0]  tri_v;
  logic [20:0] ab_prod;
  logic [15:0] cd_num;
  logic [31:0] cd_prod;

  // A/B: 1200 + 14v + floor(3v/25)
  always_comb begin
    tri_v      = 10'({2'b00, value_i} * 10'd3);
    ab_prod    = {11'd0, tri_v} * {10'd0, AB_RECIP};
    pulse_ab_o = AB_BASE + 13'({5'd0, value_i} * 13'd14) + 13'(ab_prod >> AB_SHIFT);
  end

  // C/D: floor((9080 + 106v) / 1000)
  always_comb begin
    cd_num     = CD_BASE + ({8'd0, value_i} * {9'd0, CD_SLOPE});
    cd_prod    = {16'd0, cd_num} * {16'd0, CD_RECIP};
    pulse_cd_o = PulseCdW'(cd_prod >> CD_SHIFT);
  end

endmodule

### hw/rtl/spc_msg.sv
// ============================================================================
// spc_msg
// Remote text receiver: collects characters, frames messages and parses a
// selector letter plus decimal value into a servo update.
// ============================================================================
module spc_msg import spc_pkg::*; #(
  parameter int unsigned MsgChars = MsgCharsDef
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       step_i,    // an item is processed this cycle
  input  logic       uart_i,    // the item is a received character
  input  logic [7:0] data_i,
  input  logic       remote_i,  // mode after this item is remote
  output msg_set_t   set_o
);

  localparam int unsigned IdxW = (MsgChars > 1) ? $clog2(MsgChars) : 1;

  logic [7:0]         buf_q [MsgChars];
  logic [7:0]         buf_d [MsgChars];
  logic [MsgCntW-1:0] count_q, count_d;
  logic [MsgCntW-1:0] len_q, len_d;
  logic               pending_q, pending_d;
  logic               append;
  logic               terminate;
  logic               run;
  logic [DigitValW-1:0] val;
  logic               skip;
  logic               done;
  logic [7:0]         ch;
  logic [7:0]         sel;

  // Character framing
  always_comb begin
    append    = uart_i && (data_i != CHAR_NL) && (count_q < MsgCntW'(MsgChars));
    terminate = uart_i && !append;
    buf_d     = buf_q;
    count_d   = count_q;
    len_d     = len_q;
    pending_d = pending_q;
    if (append) begin
      buf_d[count_q[IdxW-1:0]] = data_i;
      count_d = count_q + MsgCntW'(1);
    end else if (terminate) begin
      len_d     = count_q;
      count_d   = '0;
      pending_d = 1'b1;
    end
    run = remote_i && pending_d;
    if (run) begin
      pending_d = 1'b0;
    end
  end

  // Parse: skip whitespace, then read digits up to the first non-digit
  always_comb begin
    val  = '0;
    skip = 1'b1;
    done = 1'b0;
    ch   = '0;
    for (int i = 1; i < MsgChars; i++) begin
      if (MsgCntW'(i) < len_d) begin
        ch = buf_d[i];
        if (skip && ((ch == CHAR_SP) || ((ch >= CHAR_TAB) && (ch <= CHAR_CR)))) begin
          skip = 1'b1;
        end else begin
          skip = 1'b0;
          if (!done && (ch >= CHAR_0) && (ch <= CHAR_9)) begin
            val = DigitValW'(val * DigitValW'(10)) + {6'd0, ch[3:0]};
          end else begin
            done = 1'b1;
          end
        end
      end
    end
  end

  // Servo update request
  always_comb begin
    sel         = buf_d[0];
    set_o.valid = step_i && run && (len_d != '0) && (sel >= CHAR_A) && (sel <= CHAR_D);
    set_o.idx   = 2'(sel - CHAR_A);
    set_o.value = val[7:0];
  end

  // Framing state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q   <= '0;
      len_q     <= '0;
      pending_q <= 1'b0;
    end else if (step_i) begin
      count_q   <= count_d;
      len_q     <= len_d;
      pending_q <= pending_d;
    end
  end

  // Character buffer, contents valid only once written
  always_ff @(posedge clk_i) begin
    if (step_i) begin
      buf_q <= buf_d;
    end
  end

endmodule

### hw/rtl/spc_checker.sv
// ============================================================================
// spc_checker
// Port-level checks of the servo position controller, bound to the top level.
// ============================================================================
module spc_checker import spc_pkg::*; (
  input logic            clk_i,
  input logic            rst_ni,
  input logic            s_axis_tvalid,
  input logic            s_axis_tready,
  input logic            m_axis_tvalid,
  input logic            m_axis_tready,
  input logic [OutW-1:0] m_axis_tdata
);

  logic in_beat;
  logic [PulseCdW-1:0] pc;
  logic [ChanW-1:0]    nc;

  assign in_beat = s_axis_tvalid && s_axis_tready;
  assign pc      = m_axis_tdata[33:28];
  assign nc      = m_axis_tdata[42:40];

  // Stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result beat changed while stalled");

  // An input beat, then a ready sink, gives a valid result beat
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_beat ##1 m_axis_tready |=> m_axis_tvalid)
    else $error("result beat missing after input beat");

  // Next channel stays on servo channels 3 to 6
  a_chan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (nc == 3'd3) || (nc == 3'd4) || (nc == 3'd5) || (nc == 3'd6))
    else $error("next channel out of range");

  // Servo C compare value is unset or on its scale
  a_pulse_c: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (pc == '0) || ((pc >= 6'd9) && (pc <= 6'd36)))
    else $error("servo C compare value off scale");

endmodule

bind servo_position_controller spc_checker u_spc_checker (.*);

### tb/sv/servo_position_controller_tb.sv
// ----------------------------------------------------------------------------
// servo_position_controller_tb
// Self-checking bench for the four-servo controller. A short table of
// directed beats covers reset values, scale extremes, ignored commands,
// preset save/load, message cut-off and parsing. Random traffic follows, built
// mostly from well-formed mode / ADC / preset / message sequences with some
// noise. Every result beat is checked against an in-bench model of the
// controller state, under random stalls on both streams and one long sink
// hold-off.
// ----------------------------------------------------------------------------
module servo_position_controller_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import spc_pkg::*;

  localparam int ClkPeriod   = 10;
  localparam int ResetCycles = 7;
  localparam int CycleLimit  = 200000;
  localparam int HoldCycles  = 400;
  localparam int DrainCycles = 8;
  localparam int MaxReports  = 10;

  // scale terms: A/B = base + v*AbNum/AbDen, C/D = (CD_BASE + v*CD_SLOPE)/CdDen
  localparam int AbNum = 1412;
  localparam int AbDen = 100;
  localparam int CdDen = 1000;

  // unused command code, must leave the state alone
  localparam logic [CmdW-1:0] CmdReserved = 3'd7;

  // result beat layout, lowest field last
  typedef struct packed {
    logic                pad;
    logic [SlotW-1:0]    load_slot;
    logic [SlotW-1:0]    save_slot;
    logic [ChanW-1:0]    next_ch;
    logic [PulseCdW-1:0] pulse_d;
    logic [PulseCdW-1:0] pulse_c;
    logic [PulseAbW-1:0] pulse_b;
    logic [PulseAbW-1:0] pulse_a;
    logic [ModeW-1:0]    mode;
  } status_beat_t;

  typedef struct {
    logic [CmdW-1:0]  cmd;
    logic [DataW-1:0] data;
    bit               typed;
    status_beat_t     status;
  } stim_row_t;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [DataW-1:0]    s_axis_tdata = '0;
  logic [CmdW-1:0]     s_axis_tuser = '0;
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [OutW-1:0]     m_axis_tdata;

  // model state
  mode_e               cur_mode;
  logic [1:0]          adc_phase;
  logic [PulseAbW-1:0] servo_pos [4];
  logic [PulseAbW-1:0] preset_mem [PresetSlotsDef][4];
  logic [SlotW-1:0]    save_ptr;
  logic [SlotW-1:0]    load_ptr;
  logic [7:0]          msg_buf [MsgCharsDef];
  logic [MsgCntW-1:0]  msg_cnt;
  logic [MsgCntW-1:0]  msg_len;
  bit                  msg_pend;

  status_beat_t        expected_status [$];
  stim_row_t           stim_rows [$];
  int                  mismatch_cnt = 0;
  int                  effective_items = 0;
  int                  cycle_cnt = 0;
  int                  tx_idle_pct = 0;
  int                  rx_idle_pct = 0;
  bit                  hold_req = 1'b0;
  int                  hold_left = 0;

  servo_position_controller u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),   // data[7:0]
    .s_axis_tuser  (s_axis_tuser),   // cmd[2:0]
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)    // mode, pulse_a, pulse_b, pulse_c, pulse_d,
                                     // next_channel, save_slot, load_slot, pad
  );

  always #(ClkPeriod / 2) clk_i = ~clk_i;

  // Servo value 0..255 to pulse / compare value
  function automatic logic [PulseAbW-1:0] scaled_pos(input logic [1:0] idx,
                                                     input logic [7:0] v);
    if (idx == SERVO_A || idx == SERVO_B) begin
      return PulseAbW'(int'(AB_BASE) + (int'(v) * AbNum) / AbDen);
    end
    return PulseAbW'((int'(CD_BASE) + int'(v) * int'(CD_SLOPE)) / CdDen);
  endfunction

  // Advance the model by one beat; returns 0 when the command was ignored
  function automatic bit predict_status(input logic [CmdW-1:0] cmd,
                                        input logic [DataW-1:0] data,
                                        output status_beat_t beat);
    bit         taken;
    int         val;
    int         pos;
    int         i;
    logic [7:0] sel;
    taken = 1'b0;
    case (cmd)
      CMD_MODE: begin
        taken = 1'b1;
        case (cur_mode)
          MODE_MANUAL: cur_mode = MODE_PRESET;
          MODE_PRESET: cur_mode = MODE_REMOTE;
          default: begin
            cur_mode  = MODE_MANUAL;
            adc_phase = SERVO_A;
          end
        endcase
      end
      CMD_ADC: begin
        if (cur_mode == MODE_MANUAL) begin
          taken = 1'b1;
          servo_pos[adc_phase] = scaled_pos(adc_phase, data);
          adc_phase = adc_phase + 2'd1;
        end
      end
      CMD_SAVE: begin
        if (cur_mode == MODE_PRESET) begin
          taken = 1'b1;
          for (i = 0; i < 4; i++) preset_mem[save_ptr][i] = servo_pos[i];
          save_ptr = SlotW'((save_ptr + 1) % PresetSlotsDef);
        end
      end
      CMD_LOAD: begin
        if (cur_mode == MODE_PRESET) begin
          taken = 1'b1;
          for (i = 0; i < 4; i++) servo_pos[i] = preset_mem[load_ptr][i];
          load_ptr = SlotW'((load_ptr + 1) % PresetSlotsDef);
        end
      end
      CMD_UART: begin
        taken = 1'b1;
        if (data != CHAR_NL && msg_cnt < MsgCharsDef) begin
          msg_buf[msg_cnt] = data;
          msg_cnt = msg_cnt + 1'b1;
        end else begin
          // newline or overflow byte: dropped, closes the message
          msg_len  = msg_cnt;
          msg_cnt  = '0;
          msg_pend = 1'b1;
        end
      end
      default: ;
    endcase

    // a closed message takes effect once in remote mode
    if (cur_mode == MODE_REMOTE && msg_pend) begin
      msg_pend = 1'b0;
      if (msg_len != 0) begin
        sel = msg_buf[0];
        pos = 1;
        while (pos < msg_len && (msg_buf[pos] == CHAR_SP ||
               (msg_buf[pos] >= CHAR_TAB && msg_buf[pos] <= CHAR_CR))) pos++;
        val = 0;
        while (pos < msg_len && msg_buf[pos] >= CHAR_0 && msg_buf[pos] <= CHAR_9) begin
          val = (val * 10 + int'(msg_buf[pos] - CHAR_0)) & 16'hFFFF;
          pos++;
        end
        if (sel >= CHAR_A && sel <= CHAR_D) begin
          servo_pos[2'(sel - CHAR_A)] = scaled_pos(2'(sel - CHAR_A), val[7:0]);
        end
      end
    end

    beat           = '0;
    beat.mode      = cur_mode;
    beat.pulse_a   = servo_pos[SERVO_A];
    beat.pulse_b   = servo_pos[SERVO_B];
    beat.pulse_c   = servo_pos[SERVO_C][PulseCdW-1:0];
    beat.pulse_d   = servo_pos[SERVO_D][PulseCdW-1:0];
    beat.next_ch   = CHAN_FIRST - ChanW'(adc_phase);
    beat.save_slot = save_ptr;
    beat.load_slot = load_ptr;
    return taken;
  endfunction

  function automatic status_beat_t make_status(
      input mode_e m, input int a, input int b, input int c, input int d,
      input logic [ChanW-1:0] ch, input int ss, input int ls);
    status_beat_t s;
    s           = '0;
    s.mode      = m;
    s.pulse_a   = PulseAbW'(a);
    s.pulse_b   = PulseAbW'(b);
    s.pulse_c   = PulseCdW'(c);
    s.pulse_d   = PulseCdW'(d);
    s.next_ch   = ch;
    s.save_slot = SlotW'(ss);
    s.load_slot = SlotW'(ls);
    return s;
  endfunction

  function automatic void add_row(input logic [CmdW-1:0] cmd, input logic [DataW-1:0] data,
                                  input bit typed = 1'b0,
                                  input status_beat_t status = '0);
    stim_row_t r;
    r.cmd    = cmd;
    r.data   = data;
    r.typed  = typed;
    r.status = status;
    stim_rows.push_back(r);
  endfunction

  // Drive one beat at the falling edge, hold until accepted
  task automatic send_item(input logic [CmdW-1:0] cmd, input logic [DataW-1:0] data,
                           input bit typed = 1'b0, input status_beat_t status = '0);
    status_beat_t predicted;
    bit           taken;
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= data;
    s_axis_tuser  <= cmd;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    taken = predict_status(cmd, data, predicted);
    expected_status.push_back(typed ? status : predicted);
    if (taken) effective_items++;
    @(negedge clk_i);
  endtask

  // Selector, optional blank, optional sign, up to three digits; newline or cut-off
  task automatic send_message();
    logic [7:0] chars [MsgCharsDef];
    logic [7:0] blank;
    int         n;
    int         digits;
    int         i;
    if ($urandom_range(0, 99) < 85) chars[0] = CHAR_A + 8'($urandom_range(0, 3));
    else chars[0] = 8'($urandom_range(0, 255));
    n = 1;
    if ($urandom_range(0, 99) < 25) begin
      blank = ($urandom_range(0, 1) == 0) ? CHAR_SP : 8'($urandom_range(CHAR_TAB, CHAR_CR));
      chars[n] = (blank == CHAR_NL) ? CHAR_SP : blank;
      n++;
    end
    if ($urandom_range(0, 99) < 10) begin
      chars[n] = ($urandom_range(0, 1) == 0) ? "-" : "+";
      n++;
    end
    digits = $urandom_range(1, 3);
    for (i = 0; i < digits && n < MsgCharsDef; i++) begin
      chars[n] = CHAR_0 + 8'($urandom_range(0, 9));
      n++;
    end
    for (i = 0; i < n; i++) send_item(CMD_UART, chars[i]);
    if (n < MsgCharsDef || $urandom_range(0, 1) == 0) send_item(CMD_UART, CHAR_NL);
    else send_item(CMD_UART, 8'($urandom_range(0, 255)));
  endtask

  // One random sequence: mostly well-formed, some noise and broken text
  task automatic run_sequence();
    int    kind;
    int    n;
    int    i;
    mode_e want;
    kind = $urandom_range(0, 99);
    if (kind < 10) begin
      n = $urandom_range(1, 4);
      for (i = 0; i < n; i++) begin
        send_item(CmdW'($urandom_range(0, 7)), DataW'($urandom_range(0, 255)));
      end
    end else if (kind < 20) begin
      n = $urandom_range(1, 8);
      for (i = 0; i < n; i++) begin
        if ($urandom_range(0, 3) == 0) send_item(CMD_UART, CHAR_NL);
        else send_item(CMD_UART, DataW'($urandom_range(0, 255)));
      end
    end else begin
      want = (kind < 45) ? MODE_MANUAL : (kind < 65) ? MODE_PRESET : MODE_REMOTE;
      while (cur_mode != want) send_item(CMD_MODE, DataW'($urandom_range(0, 255)));
      case (want)
        MODE_MANUAL: begin
          n = $urandom_range(1, 8);
          for (i = 0; i < n; i++) send_item(CMD_ADC, DataW'($urandom_range(0, 255)));
        end
        MODE_PRESET: begin
          n = $urandom_range(1, 6);
          for (i = 0; i < n; i++) begin
            send_item(($urandom_range(0, 1) == 0) ? CMD_SAVE : CMD_LOAD,
                      DataW'($urandom_range(0, 255)));
          end
        end
        default: begin
          n = $urandom_range(1, 3);
          for (i = 0; i < n; i++) send_message();
        end
      endcase
      // text closed outside remote mode waits for the next entry into it
      if ($urandom_range(0, 99) < 20) send_message();
    end
  endtask

  // Sink: random stalls plus one long hold-off on request
  always @(negedge clk_i) begin
    if (hold_req && hold_left == 0) begin
      hold_left = HoldCycles;
      hold_req  = 1'b0;
    end
    if (hold_left > 0) begin
      hold_left--;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(0, 99) >= rx_idle_pct);
    end
  end

  // Result check against the oldest expectation
  always @(posedge clk_i) begin : result_check
    status_beat_t got;
    status_beat_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got = m_axis_tdata;
      if (expected_status.size() == 0) begin
        if (mismatch_cnt < MaxReports) begin
          $display("%0t: result beat with nothing expected: %h", $realtime, m_axis_tdata);
        end
        mismatch_cnt++;
      end else begin
        want = expected_status.pop_front();
        if (got.mode != want.mode || got.pulse_a != want.pulse_a ||
            got.pulse_b != want.pulse_b || got.pulse_c != want.pulse_c ||
            got.pulse_d != want.pulse_d || got.next_ch != want.next_ch ||
            got.save_slot != want.save_slot || got.load_slot != want.load_slot ||
            got.pad != want.pad) begin
          if (mismatch_cnt < MaxReports) begin
            $display("%0t: mismatch exp mode=%0d a=%0d b=%0d c=%0d d=%0d ch=%0d sv=%0d ld=%0d pad=%0b",
                     $realtime, want.mode, want.pulse_a, want.pulse_b, want.pulse_c,
                     want.pulse_d, want.next_ch, want.save_slot, want.load_slot, want.pad);
            $display("%0t:          got mode=%0d a=%0d b=%0d c=%0d d=%0d ch=%0d sv=%0d ld=%0d pad=%0b",
                     $realtime, got.mode, got.pulse_a, got.pulse_b, got.pulse_c,
                     got.pulse_d, got.next_ch, got.save_slot, got.load_slot, got.pad);
          end
          mismatch_cnt++;
        end
      end
    end
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt >= CycleLimit) begin
      $display("servo_position_controller_tb: FAIL");
      $finish;
    end
  end

  initial begin
    int phase;
    int target;
    // model reset
    cur_mode  = MODE_MANUAL;
    adc_phase = SERVO_A;
    save_ptr  = '0;
    load_ptr  = '0;
    msg_cnt   = '0;
    msg_len   = '0;
    msg_pend  = 1'b0;
    for (int i = 0; i < 4; i++) begin
      servo_pos[i] = '0;
      for (int j = 0; j < PresetSlotsDef; j++) preset_mem[j][i] = '0;
    end
    for (int i = 0; i < MsgCharsDef; i++) msg_buf[i] = '0;

    repeat (ResetCycles) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // directed table: reset view, scale extremes, ignored commands, presets, text
    add_row(CmdReserved, 8'hFF, 1'b1, make_status(MODE_MANUAL, 0, 0, 0, 0, CHAN_FIRST, 0, 0));
    add_row(CMD_ADC, 8'h00, 1'b1, make_status(MODE_MANUAL, 1200, 0, 0, 0, 3'd5, 0, 0));
    add_row(CMD_ADC, 8'hFF, 1'b1, make_status(MODE_MANUAL, 1200, 4800, 0, 0, 3'd4, 0, 0));
    add_row(CMD_ADC, 8'h00, 1'b1, make_status(MODE_MANUAL, 1200, 4800, 9, 0, 3'd3, 0, 0));
    add_row(CMD_ADC, 8'hFF, 1'b1, make_status(MODE_MANUAL, 1200, 4800, 9, 36, CHAN_FIRST, 0, 0));
    add_row(CMD_ADC, 8'h80);
    add_row(CMD_SAVE, 8'h00);       // save outside preset: ignored
    add_row(CMD_MODE, 8'h00);
    add_row(CMD_ADC, 8'h55);        // sample outside manual: ignored
    add_row(CMD_SAVE, 8'hAA);
    add_row(CMD_LOAD, 8'h01);
    add_row(CMD_UART, "B");         // four chars, the fifth byte cuts it
    add_row(CMD_UART, "2");
    add_row(CMD_UART, "5");
    add_row(CMD_UART, "5");
    add_row(CMD_UART, "x");
    add_row(CMD_MODE, 8'hFF);       // enter remote, pending text applies
    add_row(CMD_UART, "C");
    add_row(CMD_UART, CHAR_SP);
    add_row(CMD_UART, "9");
    add_row(CMD_UART, CHAR_NL);
    add_row(CMD_UART, CHAR_NL);     // empty message
    add_row(CMD_UART, "D");
    add_row(CMD_UART, "-");         // sign is not a digit
    add_row(CMD_UART, CHAR_NL);
    add_row(CMD_MODE, 8'h00);       // back to manual, channel restarts
    foreach (stim_rows[i]) begin
      send_item(stim_rows[i].cmd, stim_rows[i].data, stim_rows[i].typed, stim_rows[i].status);
    end

    // random traffic in three stall profiles
    for (phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin
          tx_idle_pct = 18;
          rx_idle_pct = 47;
        end
        1: begin
          tx_idle_pct = 47;
          rx_idle_pct = 18;
        end
        default: begin
          tx_idle_pct = 0;
          rx_idle_pct = 0;
          hold_req    = 1'b1;
        end
      endcase
      target = 650 * (phase + 1);
      while (effective_items < target) run_sequence();
    end
    s_axis_tvalid <= 1'b0;

    while (expected_status.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (mismatch_cnt == 0 && expected_status.size() == 0) begin
      $display("servo_position_controller_tb: PASS");
    end else begin
      $display("servo_position_controller_tb: FAIL");
    end
    $finish;
  end

endmodule
